// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== sv/mwcs_pkg.sv =====
`default_nettype none

package mwcs_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned CFG_IDX_W = $clog2(NUM_WORDS);

    localparam int unsigned ROT_W0 = 13;
    localparam int unsigned ROT_W1 = 46;
    localparam int unsigned ROT_W2 = 38;
    localparam int unsigned ROT_W3 = 7;
    localparam int unsigned ROT_W4 = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_state [NUM_WORDS];

    typedef enum logic {
        REQ_RELOAD  = 1'b0,
        REQ_ENCRYPT = 1'b1
    } t_req;

    // rotate left by a constant, 0 < n < WORD_W
    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// ===== sv/mwcs_round.sv =====
`default_nettype none

// One encrypt step: ciphertext from the old state, then the chained update.
module mwcs_round (
    input  var mwcs_pkg::t_state i_state,
    input  var mwcs_pkg::t_word  i_plain,
    output var mwcs_pkg::t_state o_state,
    output var mwcs_pkg::t_word  o_cipher
);

    mwcs_pkg::t_word w0, w1, w2, w3, w4;

    always_comb begin
        o_cipher = i_plain ^ i_state[0] ^ i_state[1] ^ (i_state[2] & i_state[3]);

        // each word sees the words already updated before it
        w0 = mwcs_pkg::rotl(i_state[0] ^ (i_state[1] & i_state[2]) ^ i_state[3],
                            mwcs_pkg::ROT_W0);
        w1 = mwcs_pkg::rotl(i_state[1] ^ i_plain ^ (i_state[2] & i_state[3]) ^ i_state[4],
                            mwcs_pkg::ROT_W1);
        w2 = mwcs_pkg::rotl(i_state[2] ^ i_plain ^ (i_state[3] & i_state[4]) ^ w0,
                            mwcs_pkg::ROT_W2);
        w3 = mwcs_pkg::rotl(i_state[3] ^ i_plain ^ (i_state[4] & w0) ^ w1,
                            mwcs_pkg::ROT_W3);
        w4 = mwcs_pkg::rotl(i_state[4] ^ i_plain ^ (w0 & w1) ^ w2,
                            mwcs_pkg::ROT_W4);

        o_state[0] = w0;
        o_state[1] = w1;
        o_state[2] = w2;
        o_state[3] = w3;
        o_state[4] = w4;
    end

endmodule

`default_nettype wire

// ===== sv/morus_word_cipher_step.sv =====
// An encrypt item's ciphertext is registered and valid the cycle after it is accepted.
// Throughput: one item per cycle; the state update is a single pass of
// XOR/AND/rotate logic into the state registers. A result left waiting holds
// the input, reloads included; a new item enters in the cycle the result is taken.
// Reset (synchronous, active low): state words and seeds clear to zero, no result pending.
`default_nettype none

module morus_word_cipher_step (
    input  var logic                               i_clk,
    input  var logic                               i_rst_n,
    input  var logic                               i_cfg_we,
    input  var logic [mwcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  var mwcs_pkg::t_word                    i_cfg_wdata,
    input  var logic                               i_in_valid,
    output var logic                               o_in_ready,
    input  var logic                               i_req_type,
    input  var mwcs_pkg::t_word                    i_plain_word,
    output var logic                               o_out_valid,
    input  var logic                               i_out_ready,
    output var mwcs_pkg::t_word                    o_cipher_word
);

    mwcs_pkg::t_state r_seed;
    mwcs_pkg::t_state r_state;
    mwcs_pkg::t_state n_state;
    mwcs_pkg::t_word  n_cipher;
    mwcs_pkg::t_word  r_cipher;
    logic             r_out_valid;
    logic             in_fire;
    logic             is_encrypt;

    mwcs_round u_round (
        .i_state  (r_state),
        .i_plain  (i_plain_word),
        .o_state  (n_state),
        .o_cipher (n_cipher)
    );

    assign o_in_ready    = !r_out_valid || i_out_ready;
    assign in_fire       = i_in_valid && o_in_ready;
    assign is_encrypt    = (mwcs_pkg::t_req'(i_req_type) == mwcs_pkg::REQ_ENCRYPT);
    assign o_out_valid   = r_out_valid;
    assign o_cipher_word = r_cipher;

    // seed registers; indexes past the last word are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
                r_seed[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
                if (i_cfg_index == mwcs_pkg::CFG_IDX_W'(i)) begin
                    r_seed[i] <= i_cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
                r_state[i] <= '0;
            end
        end else if (in_fire) begin
            if (is_encrypt) begin
                r_state <= n_state;
            end else begin
                r_state <= r_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && is_encrypt) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && is_encrypt) begin
            r_cipher <= n_cipher;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mwcs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mwcs_checker (
    input var logic                           i_clk,
    input var logic                           i_rst_n,
    input var logic                           i_in_valid,
    input var logic                           o_in_ready,
    input var logic                           i_req_type,
    input var logic                           o_out_valid,
    input var logic                           i_out_ready,
    input var mwcs_pkg::t_word                o_cipher_word
);

    logic enc_fire;
    logic reload_drain;

    assign enc_fire     = i_in_valid && o_in_ready
                          && (mwcs_pkg::t_req'(i_req_type) == mwcs_pkg::REQ_ENCRYPT);
    // reload item taken while the output slot empties: nothing may appear
    assign reload_drain = i_in_valid && o_in_ready
                          && (mwcs_pkg::t_req'(i_req_type) == mwcs_pkg::REQ_RELOAD)
                          && (!o_out_valid || i_out_ready);

    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_RUN(a_enc_gives_result, i_clk, i_rst_n, enc_fire |=> o_out_valid)
    `ASSERT_RUN(a_reload_silent, i_clk, i_rst_n, reload_drain |=> !o_out_valid)
    `ASSERT_RUN(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `ASSERT_RUN(a_out_stable, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> $stable(o_cipher_word))

endmodule

bind morus_word_cipher_step mwcs_checker u_mwcs_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_morus_word_cipher_step.sv =====
module tb_morus_word_cipher_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT    = 3000;
    localparam int unsigned RX_HOLD_CYCLES = 200;
    localparam int unsigned PRESSURE_AT    = 300;
    localparam int unsigned PHASE_ITEMS    = 140;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned CFG_IDX_LAST   = (1 << mwcs_pkg::CFG_IDX_W) - 1;

    localparam mwcs_pkg::t_word ALL_ONES = {mwcs_pkg::WORD_W{1'b1}};
    localparam mwcs_pkg::t_word ONE_LSB  = {{(mwcs_pkg::WORD_W-1){1'b0}}, 1'b1};
    localparam mwcs_pkg::t_word ONE_MSB  = {1'b1, {(mwcs_pkg::WORD_W-1){1'b0}}};
    localparam mwcs_pkg::t_word ALT_55   = {(mwcs_pkg::WORD_W/2){2'b01}};
    localparam mwcs_pkg::t_word ALT_AA   = {(mwcs_pkg::WORD_W/2){2'b10}};

    class cipher_scoreboard;
        mwcs_pkg::t_state seed_w;
        mwcs_pkg::t_state state_w;
        mwcs_pkg::t_word  cipher_due_q[$];
        int unsigned      fail_count;

        function new();
            for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
                seed_w[i]  = '0;
                state_w[i] = '0;
            end
            fail_count = 0;
        endfunction

        static function mwcs_pkg::t_word rol_word(mwcs_pkg::t_word v, int unsigned n);
            logic [2*mwcs_pkg::WORD_W-1:0] twice;
            twice = {v, v} << n;
            return twice[2*mwcs_pkg::WORD_W-1 -: mwcs_pkg::WORD_W];
        endfunction

        function void set_seed(int unsigned idx, mwcs_pkg::t_word v);
            if (idx < mwcs_pkg::NUM_WORDS) begin
                seed_w[idx] = v;
            end
        endfunction

        function int unsigned pending();
            return cipher_due_q.size();
        endfunction

        // note an accepted item: reload or encrypt-and-advance
        function void take_request(mwcs_pkg::t_req req, mwcs_pkg::t_word plain);
            mwcs_pkg::t_state w;
            if (req == mwcs_pkg::REQ_RELOAD) begin
                state_w = seed_w;
            end else begin
                w = state_w;
                cipher_due_q.push_back(plain ^ w[0] ^ w[1] ^ (w[2] & w[3]));
                // in-place update, later words see the new earlier words
                w[0] = rol_word(w[0] ^ (w[1] & w[2]) ^ w[3], mwcs_pkg::ROT_W0);
                w[1] = rol_word(w[1] ^ plain ^ (w[2] & w[3]) ^ w[4], mwcs_pkg::ROT_W1);
                w[2] = rol_word(w[2] ^ plain ^ (w[3] & w[4]) ^ w[0], mwcs_pkg::ROT_W2);
                w[3] = rol_word(w[3] ^ plain ^ (w[4] & w[0]) ^ w[1], mwcs_pkg::ROT_W3);
                w[4] = rol_word(w[4] ^ plain ^ (w[0] & w[1]) ^ w[2], mwcs_pkg::ROT_W4);
                state_w = w;
            end
        endfunction

        task report(string msg);
            fail_count++;
            $display("[%0t] %s", $time, msg);
        endtask

        task check_cipher(mwcs_pkg::t_word got);
            mwcs_pkg::t_word want;
            if (cipher_due_q.size() == 0) begin
                report($sformatf("cipher_word %h with no item pending", got));
            end else begin
                want = cipher_due_q.pop_front();
                if (got !== want) begin
                    report($sformatf("cipher_word %h, predicted %h", got, want));
                end
            end
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [mwcs_pkg::CFG_IDX_W-1:0] i_cfg_index;
    mwcs_pkg::t_word                i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_req_type;
    mwcs_pkg::t_word                i_plain_word;
    logic                           o_out_valid;
    logic                           i_out_ready;
    mwcs_pkg::t_word                o_cipher_word;

    cipher_scoreboard sb = new();
    int unsigned      items_in     = 0;
    int unsigned      burst_left   = 0;
    int unsigned      quiet_cycles = 0;

    morus_word_cipher_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_plain_word  (i_plain_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_word (o_cipher_word)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.take_request(mwcs_pkg::t_req'(i_req_type), i_plain_word);
                items_in++;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_cipher(o_cipher_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver pacing, with one long hold-off so the input backs up
    initial begin : rx_pace
        int unsigned seg_len;
        int unsigned mode;
        bit          hold_done;
        i_out_ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            if (!hold_done && items_in >= PRESSURE_AT) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 60);
            repeat (seg_len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic mwcs_pkg::t_word pick_word();
        mwcs_pkg::t_word v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = ONE_LSB << $urandom_range(0, mwcs_pkg::WORD_W - 1);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_item(input mwcs_pkg::t_req req, input mwcs_pkg::t_word plain);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_plain_word <= plain;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic cfg_write(input int unsigned idx, input mwcs_pkg::t_word data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[mwcs_pkg::CFG_IDX_W-1:0];
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_seed(idx, data);
    endtask

    // a reload gives no result, so let the block settle after the last cipher
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        mwcs_pkg::t_req req;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_req_type   = mwcs_pkg::REQ_RELOAD;
        i_plain_word = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // seeds still at reset: encrypt from the all-zero state first
        send_item(mwcs_pkg::REQ_ENCRYPT, '0);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALL_ONES);
        send_item(mwcs_pkg::REQ_RELOAD, ALL_ONES);
        send_item(mwcs_pkg::REQ_ENCRYPT, ONE_LSB);
        send_item(mwcs_pkg::REQ_ENCRYPT, ONE_MSB);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALT_55);
        send_item(mwcs_pkg::REQ_RELOAD, '0);
        send_item(mwcs_pkg::REQ_RELOAD, ALT_AA);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALT_AA);
        wait_idle();

        // all-ones seeds, then writes past the last seed must be ignored
        for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
            cfg_write(i, ALL_ONES);
        end
        for (int idx = mwcs_pkg::NUM_WORDS; idx <= CFG_IDX_LAST; idx++) begin
            cfg_write(idx, pick_word());
        end
        send_item(mwcs_pkg::REQ_RELOAD, '0);
        send_item(mwcs_pkg::REQ_ENCRYPT, '0);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALL_ONES);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALL_ONES);
        send_item(mwcs_pkg::REQ_RELOAD, ALL_ONES);
        send_item(mwcs_pkg::REQ_ENCRYPT, ALT_55);
        send_item(mwcs_pkg::REQ_ENCRYPT, '0);
        send_item(mwcs_pkg::REQ_ENCRYPT, ONE_MSB);
        wait_idle();

        cfg_write(0, '0);
        cfg_write(1, ALL_ONES);
        cfg_write(2, ALT_55);
        cfg_write(3, ALT_AA);
        cfg_write(4, ONE_MSB);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p > 0) begin
                for (int i = 0; i < mwcs_pkg::NUM_WORDS; i++) begin
                    cfg_write(i, pick_word());
                end
                if ($urandom_range(0, 1)) begin
                    cfg_write($urandom_range(mwcs_pkg::NUM_WORDS, CFG_IDX_LAST), pick_word());
                end
            end
            send_item(mwcs_pkg::REQ_RELOAD, pick_word());
            repeat (PHASE_ITEMS) begin
                req = ($urandom_range(0, 99) < 8) ? mwcs_pkg::REQ_RELOAD
                                                  : mwcs_pkg::REQ_ENCRYPT;
                send_item(req, pick_word());
            end
            wait_idle();
        end

        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d cipher words never arrived", sb.pending()));
        end
        if (sb.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
